### sv/cmfb_pkg.sv
// ----------------------------------------------------------------------------
// cmfb_pkg: shared types and constants of the crc-8 message frame buffer
// opcodes, payload structs, controller/datapath link and the j1850 fold
// ----------------------------------------------------------------------------
package cmfb_pkg;

	// buffer depth used when the top level is not overridden
	localparam int DEFAULT_DEPTH = 256;

	// crc-8/sae-j1850, msb first
	localparam logic [7:0] CRC_POLY = 8'h1D;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	typedef enum logic [2:0] {
		OP_BEGIN    = 3'd0,
		OP_APPEND   = 3'd1,
		OP_COMPLETE = 3'd2,
		OP_LOAD     = 3'd3,
		OP_CHECK    = 3'd4,
		OP_READ     = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  target_id;
		logic [15:0] command_word;
		logic [7:0]  data_byte;
		logic [7:0]  load_address;
		logic [7:0]  expected_crc;
		logic [8:0]  frame_length;
	} req_payload_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [7:0]  frame_crc;
		logic [8:0]  frame_bytes;
		logic [7:0]  header_id;
		logic [15:0] header_command;
		logic        crc_match;
		logic        overflow;
	} rsp_payload_t;

	// controller to datapath
	typedef struct packed {
		logic start;     // request accepted this cycle
		logic rd_done;   // stored byte for read next is in the read register
		logic walk;      // check is stepping through the store
		logic chk_done;  // check walk finished, report it
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pos_full;   // write/read position sits at the buffer end
		logic walk_done;  // all covered bytes folded
	} dp_status_t;

	// one byte folded into the crc, eight shift steps
	function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] c;
		c = acc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### sv/cmfb_if.sv
// ----------------------------------------------------------------------------
// cmfb_if: request and result channels of the frame buffer
// valid/ready handshake, transfer on a clock edge with both high
// ----------------------------------------------------------------------------
interface cmfb_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [7:0]  target_id;
	logic [15:0] command_word;
	logic [7:0]  data_byte;
	logic [7:0]  load_address;
	logic [7:0]  expected_crc;
	logic [8:0]  frame_length;

	modport source (
		output valid, opcode, target_id, command_word, data_byte,
		       load_address, expected_crc, frame_length,
		input  ready
	);
	modport sink (
		input  valid, opcode, target_id, command_word, data_byte,
		       load_address, expected_crc, frame_length,
		output ready
	);
endinterface

interface cmfb_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic [7:0]  frame_crc;
	logic [8:0]  frame_bytes;
	logic [7:0]  header_id;
	logic [15:0] header_command;
	logic        crc_match;
	logic        overflow;

	modport source (
		output valid, read_data, frame_crc, frame_bytes, header_id,
		       header_command, crc_match, overflow,
		input  ready
	);
	modport sink (
		input  valid, read_data, frame_crc, frame_bytes, header_id,
		       header_command, crc_match, overflow,
		output ready
	);
endinterface

### sv/crc8_message_frame_buffer.sv
// ----------------------------------------------------------------------------
// crc8_message_frame_buffer: message frame buffer with crc-8/sae-j1850
// sender side builds a frame and its crc, receiver side loads, checks, reads
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      contents
//  -------  ---  -------------  ---------------------------------------------
//  req      in   valid/ready    opcode, header fields, byte, address, length
//  rsp      out  valid/ready    read byte, crc, length, header, match, overflow
//
//  begin, append, complete, load, unknown opcodes and a read at the buffer
//  end load the result register directly on acceptance
//  read next passes the byte through the registered read port of the store
//  check folds one stored byte per step over frame_length bytes (length
//  saturated to the depth), each read through the same port, then reports
//  a new request is taken once idle and the result register is empty or
//  being emptied in the same cycle; a stalled result holds its value
//  reset clears position, crc (to 0xff), header registers and control;
//  the byte store is not cleared and holds nothing defined until written
//
module crc8_message_frame_buffer #(
	parameter int BUFFER_DEPTH = cmfb_pkg::DEFAULT_DEPTH
) (
	input logic              clk,
	input logic              arst_n,
	cmfb_req_if.sink         req,
	cmfb_rsp_if.source       rsp
);

	cmfb_pkg::dp_cmd_t      cmd;
	cmfb_pkg::dp_status_t   status;
	cmfb_pkg::req_payload_t req_data;
	cmfb_pkg::rsp_payload_t rsp_data;

	// request fields gathered for the datapath
	assign req_data.opcode       = req.opcode;
	assign req_data.target_id    = req.target_id;
	assign req_data.command_word = req.command_word;
	assign req_data.data_byte    = req.data_byte;
	assign req_data.load_address = req.load_address;
	assign req_data.expected_crc = req.expected_crc;
	assign req_data.frame_length = req.frame_length;

	// sequencing: accept, read wait, check walk
	cmfb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_opcode (req.opcode),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.status     (status),
		.cmd        (cmd)
	);

	// store, crc and result register
	cmfb_dp #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_data (req_data),
		.status   (status),
		.rsp_data (rsp_data)
	);

	// result fields out of the result register
	assign rsp.read_data      = rsp_data.read_data;
	assign rsp.frame_crc      = rsp_data.frame_crc;
	assign rsp.frame_bytes    = rsp_data.frame_bytes;
	assign rsp.header_id      = rsp_data.header_id;
	assign rsp.header_command = rsp_data.header_command;
	assign rsp.crc_match      = rsp_data.crc_match;
	assign rsp.overflow       = rsp_data.overflow;

endmodule

### sv/cmfb_dp.sv
// ----------------------------------------------------------------------------
// cmfb_dp: frame buffer datapath
// byte store, position, crc and header registers, check walker, result register
// ----------------------------------------------------------------------------
module cmfb_dp #(
	parameter int BUFFER_DEPTH = cmfb_pkg::DEFAULT_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmfb_pkg::dp_cmd_t      cmd,
	input  cmfb_pkg::req_payload_t req_data,
	output cmfb_pkg::dp_status_t   status,
	output cmfb_pkg::rsp_payload_t rsp_data
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int PW = $clog2(BUFFER_DEPTH + 1);
	localparam logic [PW-1:0] DEPTH_P = PW'(BUFFER_DEPTH);

	logic [7:0]    frame_mem [BUFFER_DEPTH];
	logic [7:0]    mem_rdata_s1;
	logic          fold_v_s1;

	logic [PW-1:0] pos_q;
	logic [7:0]    crc_q;
	logic [7:0]    id_q;
	logic [15:0]   cmd_q;
	logic [PW-1:0] idx_q;
	logic [PW-1:0] len_q;
	logic [7:0]    exp_q;
	logic [7:0]    acc_q;
	cmfb_pkg::rsp_payload_t rsp_q;

	cmfb_pkg::op_t          op;
	cmfb_pkg::rsp_payload_t rsp_next;
	logic          pos_full;
	logic          load_in_range;
	logic [PW-1:0] len_sat;
	logic          walk_issue;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    chk_crc;

	assign op            = cmfb_pkg::op_t'(req_data.opcode);
	assign pos_full      = (pos_q == DEPTH_P);
	assign load_in_range = (32'(req_data.load_address) < 32'(BUFFER_DEPTH));
	assign len_sat       = (32'(req_data.frame_length) > 32'(BUFFER_DEPTH)) ?
	                       DEPTH_P : PW'(req_data.frame_length);
	assign walk_issue    = cmd.walk && (idx_q != len_q);
	assign mem_raddr     = cmd.walk ? idx_q[AW-1:0] : pos_q[AW-1:0];
	assign chk_crc       = ~acc_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q[AW-1:0];
		if (cmd.start && op == cmfb_pkg::OP_APPEND && !pos_full) begin
			mem_we = 1'b1;
		end else if (cmd.start && op == cmfb_pkg::OP_LOAD && load_in_range) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(req_data.load_address);
		end
	end

	// byte store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_mem[mem_waddr] <= req_data.data_byte;
		end
	end

	always_ff @(posedge clk) begin
		mem_rdata_s1 <= frame_mem[mem_raddr];
	end

	// next result
	always_comb begin
		rsp_next = '0;
		if (cmd.start) begin
			case (op)
				cmfb_pkg::OP_COMPLETE: begin
					rsp_next.frame_crc      = ~crc_q;
					rsp_next.frame_bytes    = 9'(pos_q);
					rsp_next.header_id      = id_q;
					rsp_next.header_command = cmd_q;
				end
				cmfb_pkg::OP_APPEND,
				cmfb_pkg::OP_READ: begin
					rsp_next.overflow = pos_full;
				end
				default: begin
				end
			endcase
		end else if (cmd.rd_done) begin
			rsp_next.read_data = mem_rdata_s1;
		end else if (cmd.chk_done) begin
			rsp_next.frame_crc = chk_crc;
			rsp_next.crc_match = (chk_crc == exp_q);
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= cmfb_pkg::CRC_INIT;
			id_q      <= '0;
			cmd_q     <= '0;
			fold_v_s1 <= 1'b0;
		end else begin
			fold_v_s1 <= walk_issue;
			if (cmd.start) begin
				case (op)
					cmfb_pkg::OP_BEGIN: begin
						crc_q <= cmfb_pkg::CRC_INIT;
						pos_q <= '0;
						id_q  <= req_data.target_id;
						cmd_q <= req_data.command_word;
					end
					cmfb_pkg::OP_APPEND: begin
						if (!pos_full) begin
							crc_q <= cmfb_pkg::crc8_fold(crc_q, req_data.data_byte);
							pos_q <= pos_q + PW'(1);
						end
					end
					cmfb_pkg::OP_COMPLETE: begin
						crc_q <= ~crc_q;
					end
					cmfb_pkg::OP_READ: begin
						if (!pos_full) begin
							pos_q <= pos_q + PW'(1);
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.chk_done) begin
				crc_q <= chk_crc;
				pos_q <= '0;
			end
		end
	end

	// check walker and result register
	always_ff @(posedge clk) begin
		if (cmd.start && op == cmfb_pkg::OP_CHECK) begin
			len_q <= len_sat;
			exp_q <= req_data.expected_crc;
			idx_q <= '0;
			acc_q <= cmfb_pkg::CRC_INIT;
		end else begin
			if (walk_issue) begin
				idx_q <= idx_q + PW'(1);
			end
			if (fold_v_s1) begin
				acc_q <= cmfb_pkg::crc8_fold(acc_q, mem_rdata_s1);
			end
		end
		if (cmd.start || cmd.rd_done || cmd.chk_done) begin
			rsp_q <= rsp_next;
		end
	end

	assign status.pos_full  = pos_full;
	assign status.walk_done = (idx_q == len_q) && !fold_v_s1;
	assign rsp_data         = rsp_q;

endmodule

### sv/cmfb_ctrl.sv
// ----------------------------------------------------------------------------
// cmfb_ctrl: frame buffer controller
// request acceptance, read and check sequencing, result valid
// ----------------------------------------------------------------------------
module cmfb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic [2:0]           req_opcode,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  cmfb_pkg::dp_status_t status,
	output cmfb_pkg::dp_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WALK
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   accept;

	assign req_ready    = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept       = req_valid && req_ready;
	assign rsp_valid    = rsp_valid_q;

	assign cmd.start    = accept;
	assign cmd.rd_done  = (state_q == ST_READ);
	assign cmd.walk     = (state_q == ST_WALK);
	assign cmd.chk_done = (state_q == ST_WALK) && status.walk_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_opcode == cmfb_pkg::OP_READ && !status.pos_full) begin
							state_q     <= ST_READ;
							rsp_valid_q <= 1'b0;
						end else if (req_opcode == cmfb_pkg::OP_CHECK) begin
							state_q     <= ST_WALK;
							rsp_valid_q <= 1'b0;
						end else begin
							rsp_valid_q <= 1'b1;
						end
					end else if (rsp_ready) begin
						rsp_valid_q <= 1'b0;
					end
				end
				ST_READ: begin
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_WALK: begin
					if (status.walk_done) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/cmfb_checker.sv
// ----------------------------------------------------------------------------
// cmfb_checker: port level checks of the frame buffer
// result holding, request pacing and result field consistency
// ----------------------------------------------------------------------------
module cmfb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [2:0]  req_opcode,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [7:0]  rsp_read_data,
	input logic [7:0]  rsp_frame_crc,
	input logic        rsp_crc_match,
	input logic [7:0]  rsp_header_id
);

	// a waiting result stays until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before it was taken");

	// no request taken while an untaken result blocks the output
	assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !rsp_valid || rsp_ready)
		else $error("request taken while result register is stalled");

	// begin answers in the next cycle with an all-zero crc and a zero read byte
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_opcode == cmfb_pkg::OP_BEGIN |=>
		rsp_valid && rsp_frame_crc == 8'h00 && rsp_read_data == 8'h00)
		else $error("begin result wrong or late");

	// a check walks the store, so the next cycle takes no new request
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_opcode == cmfb_pkg::OP_CHECK |=> !req_ready)
		else $error("request taken during check walk");

	// a crc match only comes from check, which reports no header or byte
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_crc_match |-> rsp_header_id == 8'h00 && rsp_read_data == 8'h00)
		else $error("crc match mixed with another result");

endmodule

bind crc8_message_frame_buffer cmfb_checker u_cmfb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_opcode    (req.opcode),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_read_data (rsp.read_data),
	.rsp_frame_crc (rsp.frame_crc),
	.rsp_crc_match (rsp.crc_match),
	.rsp_header_id (rsp.header_id)
);

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the crc-8 message frame buffer
// drives requests with random hold-offs and result stalls, keeps a shadow of
// the byte store, position, crc and header, and compares every result field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
	import cmfb_pkg::*;

	localparam int DEPTH = DEFAULT_DEPTH;

	// opcodes the block leaves alone
	localparam logic [2:0] OP_RSVD_LO = 3'd6;
	localparam logic [2:0] OP_RSVD_HI = 3'd7;

	// worst case per request is a saturated check walk plus both stalls
	localparam int CYCLE_LIMIT  = 2_500_000;
	// a full check walk is the longest thing that can still be in flight
	localparam int DRAIN_CYCLES = DEPTH + 20;
	// one frame in this many is a long one
	localparam int LONG_FRAME_ODDS = 15;

	logic clk = 1'b0;
	logic arst_n;

	cmfb_req_if req_ch ();
	cmfb_rsp_if rsp_ch ();

	crc8_message_frame_buffer #(
		.BUFFER_DEPTH(DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// shadow of the block state, advanced once per accepted request
	// ------------------------------------------------------------------------
	logic [7:0]   shadow_store [DEPTH];
	bit           store_written [DEPTH];   // entries that hold a defined byte
	logic [8:0]   shadow_pos;
	logic [7:0]   shadow_crc;
	logic [7:0]   shadow_id;
	logic [15:0]  shadow_cmd;

	rsp_payload_t awaited_results [$];      // one per accepted request, in order
	int           mismatches  = 0;
	int           sent_count  = 0;
	int unsigned  cycle_count = 0;
	bit           quiet_phase = 1'b0;       // no hold-offs and no stalls once set

	// one byte through the j1850 polynomial, msb first
	function automatic logic [7:0] j1850_step(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
		return r;
	endfunction

	// check never walks past the store
	function automatic int clamp_len(input int len);
		return (len > DEPTH) ? DEPTH : len;
	endfunction

	// inverted crc over the leading stored bytes, as check reports it
	function automatic logic [7:0] stored_crc(input logic [8:0] len);
		logic [7:0] acc;
		acc = CRC_INIT;
		for (int i = 0; i < clamp_len(int'(len)); i++) acc = j1850_step(acc, shadow_store[i]);
		return ~acc;
	endfunction

	// how far a check may walk without touching an unwritten entry
	function automatic int written_prefix();
		int n;
		n = 0;
		while (n < DEPTH && store_written[n]) n++;
		return n;
	endfunction

	// a read either overflows or returns a defined byte
	function automatic bit read_in_contract();
		return shadow_pos >= DEPTH || store_written[shadow_pos];
	endfunction

	// expected result of one request; moves the shadow state on
	function automatic rsp_payload_t predict_result(input req_payload_t r);
		rsp_payload_t res;
		res = '0;
		case (r.opcode)
			OP_BEGIN: begin
				shadow_crc = CRC_INIT;
				shadow_pos = '0;
				shadow_id  = r.target_id;
				shadow_cmd = r.command_word;
			end
			OP_APPEND: begin
				// at the end the byte is dropped and the crc left alone
				if (shadow_pos >= DEPTH) begin
					res.overflow = 1'b1;
				end else begin
					shadow_store[shadow_pos]  = r.data_byte;
					store_written[shadow_pos] = 1'b1;
					shadow_crc = j1850_step(shadow_crc, r.data_byte);
					shadow_pos++;
				end
			end
			OP_COMPLETE: begin
				// the register keeps the inverted value, so a second complete flips it back
				shadow_crc         = ~shadow_crc;
				res.frame_crc      = shadow_crc;
				res.frame_bytes    = shadow_pos;
				res.header_id      = shadow_id;
				res.header_command = shadow_cmd;
			end
			OP_LOAD: begin
				if (r.load_address < DEPTH) begin
					shadow_store[r.load_address]  = r.data_byte;
					store_written[r.load_address] = 1'b1;
				end
			end
			OP_CHECK: begin
				shadow_crc    = stored_crc(r.frame_length);
				shadow_pos    = '0;
				res.frame_crc = shadow_crc;
				res.crc_match = (shadow_crc == r.expected_crc);
			end
			OP_READ: begin
				// position stays put at the end
				if (shadow_pos >= DEPTH) begin
					res.overflow = 1'b1;
				end else begin
					res.read_data = shadow_store[shadow_pos];
					shadow_pos++;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// request generation
	// ------------------------------------------------------------------------
	function automatic logic [7:0] rand_byte();
		logic [31:0] w;
		w = $urandom;
		return w[7:0];
	endfunction

	// half the checks carry the right crc, the rest a random one
	function automatic logic [7:0] random_flip();
		return ($urandom_range(0, 1) == 0) ? 8'h00 : rand_byte();
	endfunction

	// every field random, so unused fields still toggle
	function automatic req_payload_t random_request(input logic [2:0] op);
		req_payload_t r;
		logic [63:0]  w;
		w = {$urandom, $urandom};
		r.opcode       = op;
		r.target_id    = w[7:0];
		r.command_word = w[23:8];
		r.data_byte    = w[31:24];
		r.load_address = w[39:32];
		r.expected_crc = w[47:40];
		r.frame_length = w[56:48];
		return r;
	endfunction

	// mostly short walks, now and then a long or saturating one
	function automatic logic [8:0] pick_length(input int limit);
		int len;
		if ($urandom_range(0, 19) == 0) begin
			len = $urandom_range(0, 511);
		end else begin
			len = $urandom_range(0, 24);
		end
		if (clamp_len(len) > limit) len = limit;
		return 9'(len);
	endfunction

	// one request: optional hold-off, then valid held until the block takes it
	task automatic send_request(input req_payload_t r);
		if (!quiet_phase && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.opcode       <= r.opcode;
		req_ch.target_id    <= r.target_id;
		req_ch.command_word <= r.command_word;
		req_ch.data_byte    <= r.data_byte;
		req_ch.load_address <= r.load_address;
		req_ch.expected_crc <= r.expected_crc;
		req_ch.frame_length <= r.frame_length;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		awaited_results.push_back(predict_result(r));
		sent_count++;
	endtask

	task automatic send_header(input logic [7:0] id, input logic [15:0] cmd);
		req_payload_t r;
		r = random_request(OP_BEGIN);
		r.target_id    = id;
		r.command_word = cmd;
		send_request(r);
	endtask

	// append or load
	task automatic send_byte(input logic [2:0] op, input logic [7:0] addr, input logic [7:0] data);
		req_payload_t r;
		r = random_request(op);
		r.load_address = addr;
		r.data_byte    = data;
		send_request(r);
	endtask

	// expected crc is the true one with the given bits flipped
	task automatic send_check(input logic [8:0] len, input logic [7:0] flip);
		req_payload_t r;
		r = random_request(OP_CHECK);
		r.frame_length = len;
		r.expected_crc = stored_crc(len) ^ flip;
		send_request(r);
	endtask

	// any opcode from lowest_op up, kept clear of unwritten entries
	task automatic send_any(input int lowest_op);
		logic [2:0] op;
		op = 3'($urandom_range(lowest_op, 7));
		if (op == OP_CHECK) begin
			send_check(pick_length(written_prefix()), random_flip());
		end else if (op == OP_READ && !read_in_contract()) begin
			send_request(random_request(OP_RSVD_LO));
		end else begin
			send_request(random_request(op));
		end
	endtask

	// hold valid low until every result is back
	task automatic pause_until_drained();
		req_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (awaited_results.size() != 0);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// field extremes, each opcode, both crc outcomes, double complete
	task automatic test_directed();
		logic [7:0]   probe_bytes [4] = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
		req_payload_t r;
		send_check(9'd0, 8'h00);               // empty walk matches
		send_check(9'd0, 8'hFF);               // empty walk, wrong crc
		send_request(random_request(OP_COMPLETE));
		send_header(8'hFF, 16'hFFFF);
		foreach (probe_bytes[i]) send_byte(OP_APPEND, rand_byte(), probe_bytes[i]);
		send_request(random_request(OP_COMPLETE));
		send_request(random_request(OP_COMPLETE));
		send_header(8'h00, 16'h0000);
		send_request(random_request(OP_COMPLETE));   // empty frame
		send_byte(OP_LOAD, 8'hFF, 8'hFF);
		send_byte(OP_LOAD, 8'h00, 8'h00);
		send_byte(OP_LOAD, 8'h04, 8'h3C);
		send_check(9'd5, 8'h00);
		repeat (5) send_request(random_request(OP_READ));
		r = '1;
		r.opcode = OP_RSVD_LO;
		send_request(r);
		r = '0;
		r.opcode = OP_RSVD_HI;
		send_request(r);
		send_check(9'd3, 8'h80);
	endtask

	// fill the whole store by appends, run off the end, then read it all back
	task automatic test_overflow();
		send_request(random_request(OP_BEGIN));
		repeat (DEPTH) send_byte(OP_APPEND, rand_byte(), rand_byte());
		repeat (2) send_byte(OP_APPEND, rand_byte(), rand_byte());
		send_request(random_request(OP_COMPLETE));   // length of a full store
		send_request(random_request(OP_READ));       // read at the end
		send_check(9'h1FF, 8'h00);                   // saturated walk
		send_check(9'(DEPTH), 8'h00);
		send_check(9'd300, random_flip());
		repeat (DEPTH + 1) send_request(random_request(OP_READ));
	endtask

	// sender side: begin, appends, complete, with stray requests mixed in
	task automatic test_sender_frames(input int budget);
		int stop;
		int n;
		stop = sent_count + budget;
		while (sent_count < stop) begin
			// now and then a frame runs on from the last one with no begin
			if ($urandom_range(0, 9) != 0) send_request(random_request(OP_BEGIN));
			if ($urandom_range(1, LONG_FRAME_ODDS) == 1) begin
				n = $urandom_range(200, DEPTH + 4);
			end else begin
				n = $urandom_range(0, 24);
			end
			repeat (n) begin
				if ($urandom_range(0, 15) == 0) send_any(int'(OP_LOAD));
				send_byte(OP_APPEND, rand_byte(), rand_byte());
			end
			send_request(random_request(OP_COMPLETE));
			if ($urandom_range(0, 5) == 0) send_request(random_request(OP_COMPLETE));
		end
	endtask

	// receiver side: loads, a check over them, then reads
	task automatic test_receiver_frames(input int budget);
		int stop;
		int n;
		stop = sent_count + budget;
		while (sent_count < stop) begin
			if ($urandom_range(1, LONG_FRAME_ODDS) == 1) begin
				n = $urandom_range(100, DEPTH);
			end else begin
				n = $urandom_range(1, 24);
			end
			for (int a = 0; a < n; a++) begin
				if ($urandom_range(0, 15) == 0) send_any(int'(OP_LOAD));
				send_byte(OP_LOAD, 8'(a), rand_byte());
			end
			if ($urandom_range(0, 3) != 0) begin
				send_check(9'(n), random_flip());
			end else begin
				send_check(pick_length(written_prefix()), random_flip());
			end
			repeat ($urandom_range(0, n + 2)) begin
				if (read_in_contract()) send_request(random_request(OP_READ));
			end
		end
	endtask

	// anything goes; the tail runs with both sides at full rate
	task automatic test_random_mix(input int budget, input int quiet_tail);
		int stop;
		stop = sent_count + budget;
		while (sent_count < stop) begin
			if (stop - sent_count <= quiet_tail) quiet_phase = 1'b1;
			send_any(int'(OP_BEGIN));
		end
	endtask

	// ------------------------------------------------------------------------
	// result side: random stalls on ready, then check each result in order
	// ------------------------------------------------------------------------
	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!quiet_phase && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	end

	task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	rsp_payload_t want;

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_results.size() == 0) begin
				$error("result with no request outstanding");
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				compare_field("read_data",      want.read_data,      rsp_ch.read_data);
				compare_field("frame_crc",      want.frame_crc,      rsp_ch.frame_crc);
				compare_field("frame_bytes",    want.frame_bytes,    rsp_ch.frame_bytes);
				compare_field("header_id",      want.header_id,      rsp_ch.header_id);
				compare_field("header_command", want.header_command, rsp_ch.header_command);
				compare_field("crc_match",      want.crc_match,      rsp_ch.crc_match);
				compare_field("overflow",       want.overflow,       rsp_ch.overflow);
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** crc8_message_frame_buffer: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// sequence of tests
	// ------------------------------------------------------------------------
	initial begin
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.opcode       <= OP_BEGIN;
		req_ch.target_id    <= '0;
		req_ch.command_word <= '0;
		req_ch.data_byte    <= '0;
		req_ch.load_address <= '0;
		req_ch.expected_crc <= '0;
		req_ch.frame_length <= '0;
		shadow_pos = '0;
		shadow_crc = CRC_INIT;
		shadow_id  = '0;
		shadow_cmd = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_overflow();
		test_sender_frames(420);
		pause_until_drained();
		test_receiver_frames(420);
		pause_until_drained();
		test_random_mix(460, 150);

		// let the last results out, then allow for a walk still in progress
		req_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (awaited_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("** crc8_message_frame_buffer: PASSED **");
		end else begin
			$display("** crc8_message_frame_buffer: FAILED **");
		end
		$finish;
	end

endmodule

### files.f
sv/cmfb_pkg.sv
sv/cmfb_if.sv
sv/cmfb_dp.sv
sv/cmfb_ctrl.sv
sv/crc8_message_frame_buffer.sv
sv/cmfb_checker.sv
tb/sv/tb_top.sv
